// File: sv/gmdfs_pkg.sv
// ----------------------------------------------------------------------------
// gmdfs_pkg
// Shared types and constants for the grid maze depth-first solver.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

    localparam int MAX_SIDE = 8;
    localparam int SIDE_W   = 3;
    localparam int SIZE_W   = 4;
    localparam int CELL_W   = 2 * SIDE_W;
    localparam int CELLS    = 1 << CELL_W;
    localparam int DEPTH_W  = CELL_W + 1;
    localparam int DIR_W    = 3;
    localparam int FRAME_W  = DIR_W + CELL_W;
    localparam int CFG_IDX_W = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y      = 3'd5;

    typedef enum logic [1:0] {
        MOVE_N = 2'd0,
        MOVE_S = 2'd1,
        MOVE_W = 2'd2,
        MOVE_E = 2'd3
    } t_move;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_START,
        S_START_CHK,
        S_FETCH,
        S_FRAME,
        S_CHECK,
        S_PATH_RD,
        S_PATH_OUT,
        S_FAIL_OUT,
        S_EQ_OUT
    } t_state;

    typedef struct packed {
        logic       found;
        logic       has_move;
        logic [1:0] move;
        logic       last;
    } t_result;

endpackage

// File: sv/grid_maze_depth_first_solver.sv
// ----------------------------------------------------------------------------
// grid_maze_depth_first_solver
// Loads a wall map cell by cell and solves it by depth-first search with an
// explicit frame stack held in a memory, one probe step at a time.
// ----------------------------------------------------------------------------
// A load word is accepted in idle and loads may follow back to back.
// A solve word first clears the visited map, then runs each search step
// through fetch, frame and, on a probe, check over the shared probe path.
// Path words alternate read and output states; input not ready until done.
// Synchronous active-low reset returns to idle with the configuration
// registers at their defaults; the wall map is undefined until loaded.
module grid_maze_depth_first_solver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gmdfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gmdfs_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cell_col[2:0], cell_row[5:3], is_wall[6], zero[7]
    input  logic [7:0]                      s_axis_tdata,
    // opcode[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found[0], move[2:1], zero[7:3]
    output logic [7:0]                      m_axis_tdata,
    // has_move[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int SW = gmdfs_pkg::SIDE_W;
    localparam int CW = gmdfs_pkg::CELL_W;
    localparam int DW = gmdfs_pkg::DEPTH_W;
    localparam int FW = gmdfs_pkg::FRAME_W;
    localparam int ZW = gmdfs_pkg::SIZE_W;
    localparam int DIR_W_L = gmdfs_pkg::DIR_W;
    localparam logic [ZW-1:0] SIDE_MAX = ZW'(gmdfs_pkg::MAX_SIDE);
    localparam logic [DW-1:0] CNT_LAST = DW'(gmdfs_pkg::CELLS - 1);
    localparam logic [DW-1:0] STACK_MAX = DW'(gmdfs_pkg::CELLS);

    gmdfs_pkg::t_state r_state, n_state;

    logic [ZW-1:0] r_cfg_w, r_cfg_h;
    logic [SW-1:0] r_sx, r_sy, r_gx, r_gy;
    logic [ZW-1:0] r_w, r_h, n_w, n_h;
    logic [DW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_depth, n_depth;
    logic [SW-1:0] r_nx, r_ny, n_nx, n_ny;
    logic          r_ninb, n_ninb;

    logic          mem_wall [gmdfs_pkg::CELLS];
    logic          mem_vis  [gmdfs_pkg::CELLS];
    logic [FW-1:0] mem_frame[gmdfs_pkg::CELLS];
    logic          r_wall_q, r_vis_q;
    logic [FW-1:0] r_frame_q;

    logic          wall_we, wall_wdata, vis_we, vis_wdata, frm_we;
    logic [CW-1:0] wall_waddr, wall_raddr, vis_waddr, vis_raddr, frm_waddr, frm_raddr;
    logic [FW-1:0] frm_wdata;

    logic                r_out_valid;
    gmdfs_pkg::t_result  r_out, n_out;
    logic                out_load, out_free;

    logic                in_acc;
    logic [DW-1:0]       depth_m1;
    logic [SW-1:0]       q_x, q_y;
    logic [DIR_W_L-1:0]  q_dir;
    logic [SW:0]         inc_x, inc_y;
    logic                probe_fail, at_goal, path_last;
    logic [SW-1:0]       ld_col, ld_row;

    assign s_axis_tready = (r_state == gmdfs_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign depth_m1      = r_depth - DW'(1);
    assign q_x           = r_frame_q[SW-1:0];
    assign q_y           = r_frame_q[CW-1:SW];
    assign q_dir         = r_frame_q[FW-1:CW];
    assign inc_x         = {1'b0, q_x} + (SW+1)'(1);
    assign inc_y         = {1'b0, q_y} + (SW+1)'(1);
    assign probe_fail    = !r_ninb || r_wall_q || r_vis_q;
    assign at_goal       = (r_nx == r_gx) && (r_ny == r_gy);
    assign path_last     = ((r_cnt + DW'(1)) == r_depth);
    assign ld_col        = s_axis_tdata[SW-1:0];
    assign ld_row        = s_axis_tdata[CW-1:SW];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.move, r_out.found};
    assign m_axis_tuser  = r_out.has_move;
    assign m_axis_tlast  = r_out.last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gmdfs_pkg::S_IDLE: begin
                if (in_acc && s_axis_tuser == gmdfs_pkg::OP_SOLVE) n_state = gmdfs_pkg::S_CLEAR;
            end
            gmdfs_pkg::S_CLEAR: begin
                if (r_cnt == CNT_LAST) n_state = gmdfs_pkg::S_START;
            end
            gmdfs_pkg::S_START: n_state = gmdfs_pkg::S_START_CHK;
            gmdfs_pkg::S_START_CHK: begin
                if (!r_ninb || r_wall_q) n_state = gmdfs_pkg::S_FAIL_OUT;
                else if (r_sx == r_gx && r_sy == r_gy) n_state = gmdfs_pkg::S_EQ_OUT;
                else n_state = gmdfs_pkg::S_FETCH;
            end
            gmdfs_pkg::S_FETCH: begin
                if (r_depth == '0) n_state = gmdfs_pkg::S_FAIL_OUT;
                else n_state = gmdfs_pkg::S_FRAME;
            end
            gmdfs_pkg::S_FRAME: begin
                if (q_dir[DIR_W_L-1]) n_state = gmdfs_pkg::S_FETCH;
                else n_state = gmdfs_pkg::S_CHECK;
            end
            gmdfs_pkg::S_CHECK: begin
                if (!probe_fail && at_goal) n_state = gmdfs_pkg::S_PATH_RD;
                else n_state = gmdfs_pkg::S_FETCH;
            end
            gmdfs_pkg::S_PATH_RD: n_state = gmdfs_pkg::S_PATH_OUT;
            gmdfs_pkg::S_PATH_OUT: begin
                if (out_free) n_state = path_last ? gmdfs_pkg::S_IDLE : gmdfs_pkg::S_PATH_RD;
            end
            gmdfs_pkg::S_FAIL_OUT, gmdfs_pkg::S_EQ_OUT: begin
                if (out_free) n_state = gmdfs_pkg::S_IDLE;
            end
            default: n_state = gmdfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        wall_we    = 1'b0;
        wall_waddr = {ld_row, ld_col};
        wall_wdata = s_axis_tdata[CW];
        wall_raddr = {r_sy, r_sx};
        vis_we     = 1'b0;
        vis_waddr  = r_cnt[CW-1:0];
        vis_wdata  = 1'b0;
        vis_raddr  = {r_ny, r_nx};
        frm_we     = 1'b0;
        frm_waddr  = depth_m1[CW-1:0];
        frm_wdata  = r_frame_q;
        frm_raddr  = depth_m1[CW-1:0];
        n_w        = r_w;
        n_h        = r_h;
        n_cnt      = r_cnt;
        n_depth    = r_depth;
        n_nx       = r_nx;
        n_ny       = r_ny;
        n_ninb     = r_ninb;
        out_load   = 1'b0;
        n_out      = r_out;
        case (r_state)
            gmdfs_pkg::S_IDLE: begin
                if (in_acc && s_axis_tuser == gmdfs_pkg::OP_LOAD) begin
                    wall_we = ({1'b0, ld_col} < SIDE_MAX) && ({1'b0, ld_row} < SIDE_MAX);
                end
                if (in_acc && s_axis_tuser == gmdfs_pkg::OP_SOLVE) begin
                    n_w     = (r_cfg_w > SIDE_MAX) ? SIDE_MAX : r_cfg_w;
                    n_h     = (r_cfg_h > SIDE_MAX) ? SIDE_MAX : r_cfg_h;
                    n_cnt   = '0;
                    n_depth = '0;
                end
            end
            gmdfs_pkg::S_CLEAR: begin
                vis_we = 1'b1;
                n_cnt  = r_cnt + DW'(1);
            end
            gmdfs_pkg::S_START: begin
                n_ninb = ({1'b0, r_sx} < r_w) && ({1'b0, r_sy} < r_h);
                n_nx   = r_sx;
                n_ny   = r_sy;
            end
            gmdfs_pkg::S_START_CHK: begin
                if (r_ninb && !r_wall_q && !(r_sx == r_gx && r_sy == r_gy)) begin
                    vis_we    = 1'b1;
                    vis_waddr = {r_sy, r_sx};
                    vis_wdata = 1'b1;
                    frm_we    = 1'b1;
                    frm_waddr = '0;
                    frm_wdata = {DIR_W_L'(0), r_sy, r_sx};
                    n_depth   = DW'(1);
                end
            end
            gmdfs_pkg::S_FRAME: begin
                if (q_dir[DIR_W_L-1]) begin
                    n_depth = depth_m1;
                end else begin
                    frm_we    = 1'b1;
                    frm_wdata = {q_dir + DIR_W_L'(1), q_y, q_x};
                    n_nx      = q_x;
                    n_ny      = q_y;
                    case (gmdfs_pkg::t_move'(q_dir[1:0]))
                        gmdfs_pkg::MOVE_N: begin
                            n_ninb = (q_y != '0);
                            n_ny   = q_y - SW'(1);
                        end
                        gmdfs_pkg::MOVE_S: begin
                            n_ninb = ({1'b0, inc_y} < {1'b0, r_h});
                            n_ny   = inc_y[SW-1:0];
                        end
                        gmdfs_pkg::MOVE_W: begin
                            n_ninb = (q_x != '0);
                            n_nx   = q_x - SW'(1);
                        end
                        gmdfs_pkg::MOVE_E: begin
                            n_ninb = ({1'b0, inc_x} < {1'b0, r_w});
                            n_nx   = inc_x[SW-1:0];
                        end
                        default: n_ninb = 1'b0;
                    endcase
                    wall_raddr = {n_ny, n_nx};
                    vis_raddr  = {n_ny, n_nx};
                end
            end
            gmdfs_pkg::S_CHECK: begin
                if (!probe_fail && at_goal) begin
                    n_cnt = '0;
                end else if (!probe_fail) begin
                    vis_we    = 1'b1;
                    vis_waddr = {r_ny, r_nx};
                    vis_wdata = 1'b1;
                    if (r_depth < STACK_MAX) begin
                        frm_we    = 1'b1;
                        frm_waddr = r_depth[CW-1:0];
                        frm_wdata = {DIR_W_L'(0), r_ny, r_nx};
                        n_depth   = r_depth + DW'(1);
                    end
                end
            end
            gmdfs_pkg::S_PATH_RD: begin
                frm_raddr = r_cnt[CW-1:0];
            end
            gmdfs_pkg::S_PATH_OUT: begin
                frm_raddr = r_cnt[CW-1:0];
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out.found    = 1'b1;
                    n_out.has_move = 1'b1;
                    n_out.move     = q_dir[1:0] - 2'd1;
                    n_out.last     = path_last;
                    n_cnt          = r_cnt + DW'(1);
                end
            end
            gmdfs_pkg::S_FAIL_OUT, gmdfs_pkg::S_EQ_OUT: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out.found    = (r_state == gmdfs_pkg::S_EQ_OUT);
                    n_out.has_move = 1'b0;
                    n_out.move     = gmdfs_pkg::MOVE_N;
                    n_out.last     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wall_we) mem_wall[wall_waddr] <= wall_wdata;
        r_wall_q <= mem_wall[wall_raddr];
        if (vis_we) mem_vis[vis_waddr] <= vis_wdata;
        r_vis_q <= mem_vis[vis_raddr];
        if (frm_we) mem_frame[frm_waddr] <= frm_wdata;
        r_frame_q <= mem_frame[frm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gmdfs_pkg::S_IDLE;
            r_cfg_w     <= SIDE_MAX;
            r_cfg_h     <= SIDE_MAX;
            r_sx        <= '0;
            r_sy        <= '0;
            r_gx        <= SW'(7);
            r_gy        <= SW'(7);
            r_cnt       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_depth <= n_depth;
            if (out_load) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gmdfs_pkg::CFG_GRID_WIDTH:  r_cfg_w <= i_cfg_wdata;
                    gmdfs_pkg::CFG_GRID_HEIGHT: r_cfg_h <= i_cfg_wdata;
                    gmdfs_pkg::CFG_START_X:     r_sx    <= i_cfg_wdata[SW-1:0];
                    gmdfs_pkg::CFG_START_Y:     r_sy    <= i_cfg_wdata[SW-1:0];
                    gmdfs_pkg::CFG_GOAL_X:      r_gx    <= i_cfg_wdata[SW-1:0];
                    gmdfs_pkg::CFG_GOAL_Y:      r_gy    <= i_cfg_wdata[SW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_h    <= n_h;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_ninb <= n_ninb;
        if (out_load) r_out <= n_out;
    end

    a_solve_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == gmdfs_pkg::OP_SOLVE) |=> (r_state == gmdfs_pkg::S_CLEAR))
        else $error("solve did not start the visited sweep");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= STACK_MAX)
        else $error("stack depth beyond capacity");

    a_frame_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmdfs_pkg::S_FRAME || r_state == gmdfs_pkg::S_CHECK) |-> (r_depth != '0))
        else $error("frame step with an empty stack");

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == gmdfs_pkg::OP_LOAD) |=> !out_load)
        else $error("load produced an output word");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.last) |=> (r_state == gmdfs_pkg::S_IDLE))
        else $error("last word did not end the solve");

endmodule
